/* rtl/core/llti_pkg.sv */
package llti_pkg;

   // Field widths of the item payloads.
   localparam int ABS_W     = 20;
   localparam int LOG_W     = 22;
   localparam int VAL_W     = 32;
   localparam int IDX_W     = 6;
   localparam int CFG_W     = 7;
   localparam int FRAC_BITS = 17;
   localparam int INT_BITS  = LOG_W - FRAC_BITS;

   // Interpolation datapath widths.
   localparam int DEN_W = ABS_W + 1;
   localparam int DL_W  = LOG_W + 1;
   localparam int NUM_W = DEN_W + DL_W;
   localparam int QUO_W = NUM_W + 1;

   typedef logic [ABS_W-1:0] abscissa_type;
   typedef logic [LOG_W-1:0] log_type;
   typedef logic [VAL_W-1:0] value_type;
   typedef logic [1:0]       status_type;

   // Result status codes.
   localparam status_type STATUS_INTERP = 2'd0;
   localparam status_type STATUS_EXACT  = 2'd1;
   localparam status_type STATUS_RANGE  = 2'd2;

   // Request kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam log_type LOG_MAX = {LOG_W{1'b1}};

   // One stored table entry.
   typedef struct packed {
      abscissa_type x;
      log_type      lg;
   } entry_type;

   typedef logic [FRAC_BITS-1:0][VAL_W-1:0] coef_table_type;

   // Integer square root, used only to build the constant table below.
   function automatic logic [63:0] isqrt64(input logic [63:0] n);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] probe;
      rem   = n;
      root  = '0;
      probe = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Entry i holds 2^(2^-(i+1)) in Q1.31, each one the square root of the one before.
   function automatic coef_table_type make_coef_table();
      coef_table_type t;
      logic [63:0]    c;
      c = 64'h1_0000_0000;
      for (int i = 0; i < FRAC_BITS; i++) begin
         c    = isqrt64(c << 31);
         t[i] = c[VAL_W-1:0];
      end
      return t;
   endfunction

   localparam coef_table_type EXP_COEF = make_coef_table();

endpackage

/* rtl/core/llti_req_if.sv */
interface llti_req_if;
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [5:0]             entry_index;
   llti_pkg::abscissa_type abscissa;
   llti_pkg::value_type    sample_value;

   modport source (output valid, output req_type, output entry_index, output abscissa,
                   output sample_value, input ready);
   modport sink (input valid, input req_type, input entry_index, input abscissa,
                 input sample_value, output ready);
endinterface

/* rtl/core/llti_rsp_if.sv */
interface llti_rsp_if;
   logic                 valid;
   logic                 ready;
   llti_pkg::value_type  interpolated;
   llti_pkg::status_type status;

   modport source (output valid, output interpolated, output status, input ready);
   modport sink (input valid, input interpolated, input status, output ready);
endinterface

/* rtl/core/llti_log2.sv */
module llti_log2 (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  llti_pkg::value_type raw,
   output logic                done,
   output llti_pkg::log_type   log_out
);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_NORM   = 2'd1;
   localparam logic [1:0] PH_SQUARE = 2'd2;

   logic [1:0]                         phase_ff, phase_in;
   logic [31:0]                        mant_ff, mant_in;
   logic [llti_pkg::INT_BITS-1:0]      msb_ff, msb_in;
   logic [llti_pkg::FRAC_BITS-1:0]     frac_ff, frac_in;
   logic [4:0]                         step_ff, step_in;
   logic                               done_ff, done_in;
   logic [63:0]                        square;
   logic [32:0]                        sq_top;

   // One squaring of the Q1.31 mantissa per cycle.
   assign square = mant_ff * mant_ff;
   assign sq_top = square[63:31];

   // Normalize one bit a cycle, then produce one fraction bit a cycle.
   always_comb begin
      phase_in = phase_ff;
      mant_in  = mant_ff;
      msb_in   = msb_ff;
      frac_in  = frac_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               mant_in  = (raw == '0) ? 32'd1 : raw;
               msb_in   = '1;
               phase_in = PH_NORM;
            end
         end
         PH_NORM: begin
            if (mant_ff[31]) begin
               step_in  = '0;
               phase_in = PH_SQUARE;
            end else begin
               mant_in = mant_ff << 1;
               msb_in  = msb_ff - 1'b1;
            end
         end
         PH_SQUARE: begin
            frac_in = {frac_ff[llti_pkg::FRAC_BITS-2:0], sq_top[32]};
            mant_in = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
            step_in = step_ff + 1'b1;
            if (step_ff == 5'(llti_pkg::FRAC_BITS - 1)) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      mant_ff <= mant_in;
      msb_ff  <= msb_in;
      frac_ff <= frac_in;
      step_ff <= step_in;
   end

   assign done    = done_ff;
   assign log_out = {msb_ff, frac_ff};

endmodule

/* rtl/core/llti_exp2.sv */
module llti_exp2 (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  llti_pkg::log_type   log_in,
   output logic                done,
   output llti_pkg::value_type value
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_MUL   = 2'd1;
   localparam logic [1:0] PH_SHIFT = 2'd2;

   logic [1:0]                         phase_ff, phase_in;
   logic [31:0]                        mant_ff, mant_in;
   logic [llti_pkg::FRAC_BITS-1:0]     frac_ff, frac_in;
   logic [llti_pkg::INT_BITS-1:0]      k_ff, k_in;
   logic [4:0]                         step_ff, step_in;
   llti_pkg::value_type                value_ff, value_in;
   logic                               done_ff, done_in;
   logic [63:0]                        prod;

   // One table coefficient is applied per cycle.
   assign prod = mant_ff * llti_pkg::EXP_COEF[step_ff];

   // Walk the fraction bits from the top, then scale by the integer part.
   always_comb begin
      phase_in = phase_ff;
      mant_in  = mant_ff;
      frac_in  = frac_ff;
      k_in     = k_ff;
      step_in  = step_ff;
      value_in = value_ff;
      done_in  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               mant_in  = 32'h8000_0000;
               frac_in  = log_in[llti_pkg::FRAC_BITS-1:0];
               k_in     = log_in[llti_pkg::LOG_W-1:llti_pkg::FRAC_BITS];
               step_in  = '0;
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            if (frac_ff[llti_pkg::FRAC_BITS-1]) begin
               mant_in = prod[62:31];
            end
            frac_in = frac_ff << 1;
            step_in = step_ff + 1'b1;
            if (step_ff == 5'(llti_pkg::FRAC_BITS - 1)) begin
               phase_in = PH_SHIFT;
            end
         end
         PH_SHIFT: begin
            value_in = mant_ff >> (5'd31 - k_ff);
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      mant_ff  <= mant_in;
      frac_ff  <= frac_in;
      k_ff     <= k_in;
      step_ff  <= step_in;
      value_ff <= value_in;
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule

/* rtl/core/llti_div.sv */
module llti_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [llti_pkg::NUM_W-1:0]   num,
   input  logic signed [llti_pkg::DEN_W-1:0]   den,
   output logic                                done,
   output logic signed [llti_pkg::QUO_W-1:0]   quotient
);

   localparam int NW = llti_pkg::NUM_W;
   localparam int DW = llti_pkg::DEN_W;

   logic                          busy_ff, busy_in;
   logic [DW-1:0]                 rem_ff, rem_in;
   logic [NW-1:0]                 quo_ff, quo_in;
   logic [DW-1:0]                 dmag_ff, dmag_in;
   logic                          neg_ff, neg_in;
   logic [5:0]                    step_ff, step_in;
   logic                          done_ff, done_in;
   logic signed [llti_pkg::QUO_W-1:0] quotient_ff, quotient_in;
   logic [DW:0]                   trial;
   logic                          fits;
   logic [NW-1:0]                 quo_next;

   // Restoring division on magnitudes, one quotient bit per cycle.
   assign trial    = {rem_ff, quo_ff[NW-1]};
   assign fits     = trial >= {1'b0, dmag_ff};
   assign quo_next = {quo_ff[NW-2:0], fits};

   always_comb begin
      busy_in     = busy_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dmag_in     = dmag_ff;
      neg_in      = neg_ff;
      step_in     = step_ff;
      quotient_in = quotient_ff;
      done_in     = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            quo_in  = num[NW-1] ? NW'(-num) : NW'(num);
            dmag_in = den[DW-1] ? DW'(-den) : DW'(den);
            neg_in  = num[NW-1] ^ den[DW-1];
            rem_in  = '0;
            step_in = '0;
            busy_in = 1'b1;
         end
      end else begin
         rem_in  = fits ? DW'(trial - {1'b0, dmag_ff}) : trial[DW-1:0];
         quo_in  = quo_next;
         step_in = step_ff + 1'b1;
         if (step_ff == 6'(NW - 1)) begin
            // Quotient is truncated toward zero.
            quotient_in = neg_ff ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
            done_in     = 1'b1;
            busy_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dmag_ff     <= dmag_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      quotient_ff <= quotient_in;
   end

   assign done     = done_ff;
   assign quotient = quotient_ff;

endmodule

/* rtl/core/log_linear_table_interpolator.sv */
// Channel    Direction  Payload
// req_chan   in         req_type, entry_index, abscissa, sample_value
// rsp_chan   out        interpolated, status
// csr_write  in         entries_in_use (7 bits), write only
//
// One item is worked on at a time. A load normalizes the mantissa one bit at a
// time, then takes 17 squaring steps in the log unit. A query walks the table
// one entry per cycle through the table memory's read port, then may wait on
// the bit-serial divider before the exponent unit; out-of-range queries skip
// the walk, the divider and the exponent unit.
// Reset clears control state and sets entries_in_use to 1; table contents
// are undefined until loaded. A finished result waits in the output register
// while the next item is accepted.
module log_linear_table_interpolator #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   llti_req_if.sink                          req_chan,
   llti_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [llti_pkg::CFG_W-1:0]        csr_write_data
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int N_W    = llti_pkg::CFG_W + ADDR_W;
   localparam int IW_W   = llti_pkg::IDX_W + ADDR_W;
   localparam int SUM_W  = llti_pkg::QUO_W + 2;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_LOG     = 4'd1;
   localparam logic [3:0] S_FIRST   = 4'd2;
   localparam logic [3:0] S_RANGE   = 4'd3;
   localparam logic [3:0] S_WALK    = 4'd4;
   localparam logic [3:0] S_MUL     = 4'd5;
   localparam logic [3:0] S_DIV     = 4'd6;
   localparam logic [3:0] S_DIVWAIT = 4'd7;
   localparam logic [3:0] S_SUM     = 4'd8;
   localparam logic [3:0] S_EXP     = 4'd9;
   localparam logic [3:0] S_OUT     = 4'd10;

   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(llti_pkg::LOG_MAX);

   logic [3:0]                              state_ff, state_in;
   logic [llti_pkg::CFG_W-1:0]              entries_ff, entries_in;
   llti_pkg::abscissa_type                  x_ff, x_in;
   logic [llti_pkg::IDX_W-1:0]              idx_ff, idx_in;
   llti_pkg::entry_type                     left_ff, left_in;
   llti_pkg::entry_type                     right_ff, right_in;
   logic [ADDR_W-1:0]                       walk_ff, walk_in;
   logic signed [llti_pkg::NUM_W-1:0]       num_ff, num_in;
   logic signed [llti_pkg::DEN_W-1:0]       den_ff, den_in;
   logic signed [llti_pkg::QUO_W-1:0]       quo_ff, quo_in;
   llti_pkg::value_type                     res_value_ff, res_value_in;
   llti_pkg::status_type                    res_status_ff, res_status_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   llti_pkg::value_type                     rsp_value_ff, rsp_value_in;
   llti_pkg::status_type                    rsp_status_ff, rsp_status_in;

   llti_pkg::entry_type                     mem [TABLE_DEPTH];
   llti_pkg::entry_type                     rd_entry_ff;
   logic [ADDR_W-1:0]                       rd_addr;
   logic                                    mem_we;
   logic [ADDR_W-1:0]                       wr_addr;
   logic [IW_W-1:0]                         idx_wide;
   logic                                    idx_ok;

   logic [N_W-1:0]                          n_wide, n_eff, last_full;
   logic [ADDR_W-1:0]                       last_idx;

   logic                                    log_start, log_done;
   llti_pkg::log_type                       log_out;
   logic                                    exp_start, exp_done;
   llti_pkg::log_type                       exp_log;
   llti_pkg::value_type                     exp_value;
   logic                                    div_start, div_done;
   logic signed [llti_pkg::QUO_W-1:0]       div_quotient;

   logic signed [llti_pkg::DEN_W-1:0]       dx, dxr;
   logic signed [llti_pkg::DL_W-1:0]        dl;
   logic signed [SUM_W-1:0]                 sum;
   llti_pkg::log_type                       sum_clamped;

   // Arithmetic units.
   llti_log2 u_log2 (
      .clock   (clock),
      .reset   (reset),
      .start   (log_start),
      .raw     (req_chan.sample_value),
      .done    (log_done),
      .log_out (log_out)
   );

   llti_exp2 u_exp2 (
      .clock  (clock),
      .reset  (reset),
      .start  (exp_start),
      .log_in (exp_log),
      .done   (exp_done),
      .value  (exp_value)
   );

   llti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_ff),
      .den      (den_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Effective entry count, forced into 1..TABLE_DEPTH.
   always_comb begin
      n_wide = N_W'(entries_ff);
      if (n_wide == '0) begin
         n_eff = N_W'(1);
      end else if (n_wide > N_W'(TABLE_DEPTH)) begin
         n_eff = N_W'(TABLE_DEPTH);
      end else begin
         n_eff = n_wide;
      end
      last_full = n_eff - 1'b1;
   end
   assign last_idx = last_full[ADDR_W-1:0];

   // Load address; indexes past the table are dropped.
   assign idx_wide = IW_W'(idx_ff);
   assign wr_addr  = idx_wide[ADDR_W-1:0];
   assign idx_ok   = idx_wide < IW_W'(TABLE_DEPTH);

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= '{x: x_ff, lg: log_out};
      end
      rd_entry_ff <= mem[rd_addr];
   end

   // Interpolation arithmetic.
   assign dx  = $signed({1'b0, x_ff}) - $signed({1'b0, left_ff.x});
   assign dxr = $signed({1'b0, right_ff.x}) - $signed({1'b0, left_ff.x});
   assign dl  = $signed({1'b0, right_ff.lg}) - $signed({1'b0, left_ff.lg});
   assign sum = $signed(SUM_W'(left_ff.lg)) + SUM_W'(quo_ff);

   always_comb begin
      if (sum < 0) begin
         sum_clamped = '0;
      end else if (sum > SUM_MAX) begin
         sum_clamped = llti_pkg::LOG_MAX;
      end else begin
         sum_clamped = sum[llti_pkg::LOG_W-1:0];
      end
   end

   // Sequencer: load, range check, table walk, interpolate, exponentiate.
   always_comb begin
      state_in      = state_ff;
      entries_in    = csr_write_enable ? csr_write_data : entries_ff;
      x_in          = x_ff;
      idx_in        = idx_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      walk_in       = walk_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      quo_in        = quo_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = '0;
      mem_we        = 1'b0;
      log_start     = 1'b0;
      exp_start     = 1'b0;
      exp_log       = left_ff.lg;
      div_start     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               x_in   = req_chan.abscissa;
               idx_in = req_chan.entry_index;
               if (req_chan.req_type == llti_pkg::REQ_LOAD) begin
                  log_start = 1'b1;
                  state_in  = S_LOG;
               end else begin
                  state_in = S_FIRST;
               end
            end
         end
         S_LOG: begin
            if (log_done) begin
               mem_we   = idx_ok;
               state_in = S_IDLE;
            end
         end
         S_FIRST: begin
            left_in  = rd_entry_ff;
            rd_addr  = last_idx;
            state_in = S_RANGE;
         end
         S_RANGE: begin
            if (x_ff < left_ff.x || x_ff > rd_entry_ff.x) begin
               res_value_in  = '0;
               res_status_in = llti_pkg::STATUS_RANGE;
               state_in      = S_OUT;
            end else if (last_idx == '0) begin
               exp_start     = 1'b1;
               exp_log       = left_ff.lg;
               res_status_in = llti_pkg::STATUS_EXACT;
               state_in      = S_EXP;
            end else begin
               rd_addr  = ADDR_W'(1);
               walk_in  = ADDR_W'(1);
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // The next entry is read ahead while this one is compared.
            rd_addr = walk_ff + 1'b1;
            if (x_ff > rd_entry_ff.x) begin
               left_in = rd_entry_ff;
               walk_in = walk_ff + 1'b1;
            end else if (x_ff == rd_entry_ff.x) begin
               exp_start     = 1'b1;
               exp_log       = rd_entry_ff.lg;
               res_status_in = llti_pkg::STATUS_EXACT;
               state_in      = S_EXP;
            end else begin
               right_in = rd_entry_ff;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            num_in   = llti_pkg::NUM_W'(dx) * llti_pkg::NUM_W'(dl);
            den_in   = dxr;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (den_ff == '0) begin
               quo_in   = '0;
               state_in = S_SUM;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIVWAIT;
            end
         end
         S_DIVWAIT: begin
            if (div_done) begin
               quo_in   = div_quotient;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            exp_start     = 1'b1;
            exp_log       = sum_clamped;
            res_status_in = llti_pkg::STATUS_INTERP;
            state_in      = S_EXP;
         end
         S_EXP: begin
            if (exp_done) begin
               res_value_in = exp_value;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         entries_ff   <= llti_pkg::CFG_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entries_ff   <= entries_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff          <= x_in;
      idx_ff        <= idx_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      walk_ff       <= walk_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      quo_ff        <= quo_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.interpolated = rsp_value_ff;
   assign rsp_chan.status       = rsp_status_ff;

`ifndef SYNTHESIS
   // An out-of-range result always carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == llti_pkg::STATUS_RANGE
      |-> rsp_chan.interpolated == '0)
      else $error("out-of-range item with nonzero value");

   // The walk never passes the last entry in use.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> walk_ff <= last_idx)
      else $error("table walk beyond last entry");

   // The log unit finishes only while a load waits for it.
   assert property (@(posedge clock) disable iff (reset)
      log_done |-> state_ff == S_LOG)
      else $error("log result with no load pending");

   // The exponent unit finishes only while a query waits for it.
   assert property (@(posedge clock) disable iff (reset)
      exp_done |-> state_ff == S_EXP)
      else $error("exponent result with no query pending");

   // An accepted item always starts work.
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> state_ff != S_IDLE)
      else $error("accepted item was dropped");
`endif

endmodule

/* bench/tb_log_linear_table_interpolator.sv */
module tb_log_linear_table_interpolator;

   localparam int DEPTH       = 64;
   localparam int HALF_PERIOD = 4;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int LOAD_SETTLE = 60;
   localparam int END_DRAIN   = 200;
   localparam int HOLD_CYCLES = 3000;
   localparam int RAND_PHASES = 8;
   localparam int QUERIES_PER_PHASE = 76;

   typedef struct {
      llti_pkg::value_type  value;
      llti_pkg::status_type status;
   } result_type;

   typedef enum int {ROW_LOAD, ROW_QUERY, ROW_SETN} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [5:0]             idx;
      llti_pkg::abscissa_type x;
      llti_pkg::value_type    sample;
      bit                     typed;
      llti_pkg::value_type    value;
      llti_pkg::status_type   status;
   } row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write_enable;
   logic [llti_pkg::CFG_W-1:0]    csr_write_data;

   llti_req_if req_if ();
   llti_rsp_if rsp_if ();

   log_linear_table_interpolator #(.TABLE_DEPTH(DEPTH)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Shadow copy of the block's state.
   llti_pkg::abscissa_type     x_store [DEPTH];
   llti_pkg::log_type          log_store [DEPTH];
   logic [llti_pkg::CFG_W-1:0] n_setting;
   logic [63:0]                exp_coef [1:llti_pkg::FRAC_BITS];

   row_type    rows [$];
   result_type pending_results [$];
   int failures = 0;
   int cycles = 0;
   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   // Bitwise integer square root.
   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] step;
      r = '0;
      step = 64'h1 << 62;
      while (step > n) step = step >> 2;
      while (step != 0) begin
         if (n >= r + step) begin
            n = n - (r + step);
            r = (r >> 1) + step;
         end else begin
            r = r >> 1;
         end
         step = step >> 2;
      end
      return r;
   endfunction

   // Log2 of a Q16.16 raw value as unsigned Q5.17, by repeated squaring.
   function automatic llti_pkg::log_type log2_q17(input llti_pkg::value_type raw);
      int                             msb;
      logic [63:0]                    m;
      logic [llti_pkg::FRAC_BITS-1:0] frac;
      if (raw == 0) raw = 1;
      msb = 0;
      while (msb < 31 && (raw >> (msb + 1)) != 0) msb++;
      m = 64'(raw) << (31 - msb);
      frac = '0;
      for (int i = 0; i < llti_pkg::FRAC_BITS; i++) begin
         m = (m * m) >> 31;
         frac = {frac[llti_pkg::FRAC_BITS-2:0], 1'b0};
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return {llti_pkg::INT_BITS'(msb), frac};
   endfunction

   // Exponentiate a Q5.17 log back to Q16.16 with saturation.
   function automatic llti_pkg::value_type exp2_q16(input llti_pkg::log_type l);
      int          k;
      logic [63:0] m;
      logic [63:0] r;
      k = int'(l[llti_pkg::LOG_W-1:llti_pkg::FRAC_BITS]);
      m = 64'h8000_0000;
      for (int i = 1; i <= llti_pkg::FRAC_BITS; i++) begin
         if (l[llti_pkg::FRAC_BITS-i]) m = (m * exp_coef[i]) >> 31;
      end
      r = m >> (31 - k);
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      return r[31:0];
   endfunction

   // Expected result of a query against the shadow table.
   function automatic result_type predict_query(input llti_pkg::abscissa_type x);
      int         n;
      result_type res;
      longint     xl, xr, ll, lr, den, l;
      n = int'(n_setting);
      if (n == 0) n = 1;
      if (n > DEPTH) n = DEPTH;
      if (x < x_store[0] || x > x_store[n-1]) begin
         res.value = '0;
         res.status = llti_pkg::STATUS_RANGE;
         return res;
      end
      if (n == 1) begin
         res.value = exp2_q16(log_store[0]);
         res.status = llti_pkg::STATUS_EXACT;
         return res;
      end
      for (int i = 0; i + 1 < n; i++) begin
         if (x > x_store[i+1]) continue;
         if (x == x_store[i+1]) begin
            res.value = exp2_q16(log_store[i+1]);
            res.status = llti_pkg::STATUS_EXACT;
            return res;
         end
         xl = longint'(x_store[i]);
         xr = longint'(x_store[i+1]);
         ll = longint'(log_store[i]);
         lr = longint'(log_store[i+1]);
         den = xr - xl;
         l = ll;
         if (den != 0) l = ll + ((longint'(x) - xl) * (lr - ll)) / den;
         if (l < 0) l = 0;
         if (l > longint'(llti_pkg::LOG_MAX)) l = longint'(llti_pkg::LOG_MAX);
         res.value = exp2_q16(llti_pkg::log_type'(l));
         res.status = llti_pkg::STATUS_INTERP;
         return res;
      end
      res.value = exp2_q16(log_store[n-1]);
      res.status = llti_pkg::STATUS_EXACT;
      return res;
   endfunction

   // Append one row to the stimulus table.
   function automatic void add_row(input row_kind_type kind, input int idx, input int x,
                                   input longint sample, input bit typed = 1'b0,
                                   input longint value = 0,
                                   input llti_pkg::status_type status =
                                      llti_pkg::STATUS_INTERP);
      row_type row;
      row.kind = kind;
      row.idx = idx[5:0];
      row.x = x[llti_pkg::ABS_W-1:0];
      row.sample = sample[31:0];
      row.typed = typed;
      row.value = value[31:0];
      row.status = status;
      rows = {rows, row};
   endfunction

   // Offer one item, wait for its acceptance, then update the shadow state.
   task automatic send_item(input logic kind, input logic [5:0] idx,
                            input llti_pkg::abscissa_type x,
                            input llti_pkg::value_type sample, input bit typed = 1'b0,
                            input llti_pkg::value_type value = '0,
                            input llti_pkg::status_type status = llti_pkg::STATUS_INTERP);
      result_type want;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= kind;
      req_if.entry_index <= idx;
      req_if.abscissa <= x;
      req_if.sample_value <= sample;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (kind == llti_pkg::REQ_LOAD) begin
         x_store[idx] = x;
         log_store[idx] = log2_q17(sample);
      end else begin
         if (typed) begin
            want.value = value;
            want.status = status;
         end else begin
            want = predict_query(x);
         end
         pending_results = {pending_results, want};
      end
   endtask

   // Write the entry count only once the block has gone quiet.
   task automatic set_entries(input logic [llti_pkg::CFG_W-1:0] count);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LOAD_SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      n_setting = count;
   endtask

   // Result side: random stalls, an optional long hold, and the item check.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               $error("result item with nothing expected: interpolated %h status %0d",
                      rsp_if.interpolated, rsp_if.status);
               failures++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_if.interpolated !== want.value) begin
                  $error("interpolated expected %h actual %h", want.value,
                         rsp_if.interpolated);
                  failures++;
               end
               if (rsp_if.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_if.status);
                  failures++;
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [llti_pkg::CFG_W-1:0] phase_counts [RAND_PHASES];
      logic [63:0]                c;
      int                         cur, gap, n, pick, a, b;
      llti_pkg::abscissa_type     tmp_x, x, lo, hi;
      llti_pkg::value_type        s;

      req_if.valid = 1'b0;
      req_if.req_type = llti_pkg::REQ_LOAD;
      req_if.entry_index = '0;
      req_if.abscissa = '0;
      req_if.sample_value = '0;
      rsp_if.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      n_setting = 1;

      c = 64'h1_0000_0000;
      for (int i = 1; i <= llti_pkg::FRAC_BITS; i++) begin
         c = int_sqrt(c << 31);
         exp_coef[i] = c;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: one entry after reset, then a short table with a
      // repeated abscissa, a zero sample and the full-scale sample.
      add_row(ROW_LOAD, 0, 'h00100, 'h0001_0000);
      add_row(ROW_QUERY, 0, 'h00100, 0, 1, 'h0001_0000, llti_pkg::STATUS_EXACT);
      add_row(ROW_QUERY, 0, 'h000FF, 0, 1, 0, llti_pkg::STATUS_RANGE);
      add_row(ROW_QUERY, 0, 'h00101, 0, 1, 0, llti_pkg::STATUS_RANGE);
      add_row(ROW_LOAD, 1, 'h00200, 'h0004_0000);
      add_row(ROW_LOAD, 2, 'h00200, 0);
      add_row(ROW_LOAD, 3, 'hFFFFF, 'hFFFF_FFFF);
      add_row(ROW_SETN, 0, 0, 4);
      add_row(ROW_QUERY, 0, 'h00100, 0, 1, 'h0001_0000, llti_pkg::STATUS_INTERP);
      add_row(ROW_QUERY, 0, 'h00180, 0);
      add_row(ROW_QUERY, 0, 'h00200, 0, 1, 'h0004_0000, llti_pkg::STATUS_EXACT);
      add_row(ROW_QUERY, 0, 'h00201, 0);
      add_row(ROW_QUERY, 0, 'h80000, 0);
      add_row(ROW_QUERY, 0, 'hFFFFF, 0);
      add_row(ROW_QUERY, 0, 'h00000, 0, 1, 0, llti_pkg::STATUS_RANGE);
      add_row(ROW_LOAD, 4, 'h00150, 'h1234_5678);
      add_row(ROW_SETN, 0, 0, 5);
      add_row(ROW_QUERY, 0, 'h00150, 0);
      add_row(ROW_QUERY, 0, 'h00120, 0);
      add_row(ROW_SETN, 0, 0, 0);
      add_row(ROW_QUERY, 0, 'h00100, 0, 1, 'h0001_0000, llti_pkg::STATUS_EXACT);
      add_row(ROW_QUERY, 0, 'h00000, 0, 1, 0, llti_pkg::STATUS_RANGE);

      foreach (rows[i]) begin
         case (rows[i].kind)
            ROW_LOAD: begin
               send_item(llti_pkg::REQ_LOAD, rows[i].idx, rows[i].x, rows[i].sample);
            end
            ROW_QUERY: begin
               send_item(llti_pkg::REQ_QUERY, '0, rows[i].x, '0, rows[i].typed,
                         rows[i].value, rows[i].status);
            end
            default: begin
               set_entries(rows[i].sample[llti_pkg::CFG_W-1:0]);
            end
         endcase
      end

      // Random part: each phase loads a whole table, then queries it with occasional loads mixed in.
      phase_counts = '{7'd64, 7'd1, 7'd2, 7'd127, 7'd33, 7'd64, 7'd0, 7'd0};
      phase_counts[7] = 7'($urandom_range(3, 64));
      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 63; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 63; end
            default: begin sender_idle_pct = 30; rsp_stall_pct = 30; end
         endcase
         set_entries(phase_counts[p]);

         // Build an ascending table with some repeated abscissas; some phases
         // scramble a few entries out of order.
         cur = (p == 0) ? 0 : $urandom_range(0, 2000);
         for (int i = 0; i < DEPTH; i++) begin
            gap = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 30000);
            if (i > 0) cur = cur + gap;
            if (cur > 'hFFFFF) cur = 'hFFFFF;
            if (p == 0 && i == DEPTH - 1) cur = 'hFFFFF;
            x_store[i] = cur[llti_pkg::ABS_W-1:0];
         end
         if (p % 4 == 3) begin
            repeat (3) begin
               a = $urandom_range(0, DEPTH - 1);
               b = $urandom_range(0, DEPTH - 1);
               tmp_x = x_store[a];
               x_store[a] = x_store[b];
               x_store[b] = tmp_x;
            end
         end
         for (int i = 0; i < DEPTH; i++) begin
            pick = $urandom_range(99);
            if (pick < 5) s = '0;
            else if (pick < 10) s = '1;
            else if (pick < 30) s = $urandom_range(1, 255);
            else s = $urandom;
            send_item(llti_pkg::REQ_LOAD, 6'(i), x_store[i], s);
         end

         // Long hold on the result side so the block backs up its input.
         if (p == 1) hold_requests++;

         n = int'(n_setting);
         if (n == 0) n = 1;
         if (n > DEPTH) n = DEPTH;
         for (int q = 0; q < QUERIES_PER_PHASE; q++) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
               send_item(llti_pkg::REQ_LOAD, 6'($urandom_range(0, DEPTH - 1)),
                         llti_pkg::abscissa_type'($urandom),
                         llti_pkg::value_type'($urandom));
            end else begin
               if (pick < 20) begin
                  x = x_store[$urandom_range(0, n - 1)];
               end else if (pick < 35) begin
                  x = llti_pkg::abscissa_type'($urandom);
               end else begin
                  lo = x_store[0];
                  hi = x_store[n-1];
                  x = llti_pkg::abscissa_type'($urandom_range(lo, hi));
               end
               send_item(llti_pkg::REQ_QUERY, 6'($urandom), x,
                         llti_pkg::value_type'($urandom));
            end
         end
      end

      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (END_DRAIN) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/llti_pkg.sv
rtl/core/llti_req_if.sv
rtl/core/llti_rsp_if.sv
rtl/core/llti_log2.sv
rtl/core/llti_exp2.sv
rtl/core/llti_div.sv
rtl/core/log_linear_table_interpolator.sv
bench/tb_log_linear_table_interpolator.sv
